>>> rtl/core/rc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pkg: shared types and constants of the reachability closure block
// widths, item codes, the token that travels down the cell chain, row helpers
// ----------------------------------------------------------------------------
package rc_pkg;

  // vertex fields are six bits wide, one cell per addressable vertex
  localparam int VTX_W        = 6;
  localparam int MAX_VERTICES = 2 ** VTX_W;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int CFG_W        = 7;
  localparam int CFG_AW       = 2;
  localparam int VC_RESET     = 64;

  // item kinds on the input channel
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // register addresses
  localparam logic [CFG_AW-1:0] ADDR_VC = '0;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_FETCH,
    OP_APPLY,
    OP_QUERY
  } op_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic [CNT_W-1:0] n;
    row_t             data;
    logic             hit;
    logic             oor;
  } tok_t;

  function automatic row_t ident_row(input logic [VTX_W-1:0] idx);
    row_t r;
    r      = '0;
    r[idx] = 1'b1;
    return r;
  endfunction

  // bits below n set, the rest clear
  function automatic row_t low_mask(input logic [CNT_W-1:0] n);
    row_t r;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      r[j] = (CNT_W'(j) < n);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/rc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_if: channel interfaces of the reachability closure block
// item channel (kind and two vertices) and result channel (reachable, flag)
// ----------------------------------------------------------------------------
interface rc_in_if import rc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [VTX_W-1:0] vertex_a;
  logic [VTX_W-1:0] vertex_b;

  modport source (output valid, output kind, output vertex_a, output vertex_b,
                  input ready);
  modport sink (input valid, input kind, input vertex_a, input vertex_b,
                output ready);
endinterface

interface rc_out_if ();
  logic valid;
  logic ready;
  logic reachable;
  logic out_of_range;

  modport source (output valid, output reachable, output out_of_range, input ready);
  modport sink (input valid, input reachable, input out_of_range, output ready);
endinterface

>>> rtl/core/reachability_closure.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reachability_closure: reachability over an undirected graph
// adjacency matrix held in a chain of row cells, closure by pivot sweeps
// ----------------------------------------------------------------------------
// usage
//   in_ch beats carry kind, vertex_a, vertex_b: add edge, close, or query
//   out_ch gives one beat per query: reachable and out_of_range
//   vertex_count is written over the apb port at byte address 0 (reset 64),
//   values above 64 act as 64; a close uses the count seen when it is taken
// timing
//   add and query beats are taken one per cycle while no close runs and the
//   chain is not frozen; each travels the chain of 64 row cells, then a query answer shows on out_ch
//   a close holds in_ch.ready low while it steps through the pivots: per
//   pivot a fetch token walks all 64 cells to pick up the pivot row, then an
//   apply token follows it down and merges it into each row in use that has
//   the pivot bit set
// reset
//   synchronous, active low; matrix returns to identity at once, no sweep
// stall
//   an output register plus a skid entry hold answers; when both are full
//   the whole chain freezes and in_ch.ready drops until out_ch.ready returns
// ----------------------------------------------------------------------------
module reachability_closure import rc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rc_in_if.sink             in_ch,
  rc_out_if.source          out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef struct packed {
    logic reach;
    logic oor;
  } res_t;

  // configuration register
  logic [CFG_W-1:0] vc_r;
  logic [CNT_W-1:0] n_act;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_VC);
  assign prdata = (paddr == ADDR_VC) ? {{(32 - CFG_W){1'b0}}, vc_r} : '0;

  // effective count, capped at the number of cells
  assign n_act = (vc_r > CFG_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(vc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= CFG_W'(VC_RESET);
    end else if (cfg_wr) begin
      vc_r <= pwdata[CFG_W-1:0];
    end
  end

  // chain advance: frozen only while the skid entry is occupied
  logic adv;
  logic skid_v_r, skid_v_nxt;
  assign adv = !skid_v_r;

  // token links between cells, head from the sequencer, tail into the output
  tok_t link [MAX_VERTICES+1];

  rc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_a     (in_ch.vertex_a),
    .in_b     (in_ch.vertex_b),
    .n_act    (n_act),
    .tail     (link[MAX_VERTICES]),
    .in_ready (in_ch.ready),
    .head     (link[0])
  );

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    rc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .idx   (VTX_W'(g)),
      .tok_i (link[g]),
      .tok_o (link[g+1])
    );
  end

  // answers leave the chain tail into an output register with one skid entry
  logic push, pop;
  res_t push_d;
  logic out_v_r, out_v_nxt;
  res_t out_d_r, out_d_nxt;
  res_t skid_d_r, skid_d_nxt;

  assign push         = adv && link[MAX_VERTICES].valid && (link[MAX_VERTICES].op == OP_QUERY);
  assign push_d.reach = link[MAX_VERTICES].hit && !link[MAX_VERTICES].oor;
  assign push_d.oor   = link[MAX_VERTICES].oor;
  assign pop          = out_v_r && out_ch.ready;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_d;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.reachable    = out_d_r.reach;
  assign out_ch.out_of_range = out_d_r.oor;

endmodule

>>> rtl/core/rc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_cell: one row of the adjacency matrix
// holds its row, acts on the token passing by and hands it to the next cell
// ----------------------------------------------------------------------------
module rc_cell import rc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [VTX_W-1:0] idx,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  row_t row_r, row_nxt;
  tok_t tok_r, tok_nxt;

  always_comb begin
    row_nxt = row_r;
    tok_nxt = tok_i;
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_ADD: begin
          if (tok_i.a == idx) row_nxt[tok_i.b] = 1'b1;
          if (tok_i.b == idx) row_nxt[tok_i.a] = 1'b1;
        end
        OP_FETCH: begin
          if (tok_i.a == idx) tok_nxt.data = row_r;
        end
        OP_APPLY: begin
          // pivot row arrives already masked to the vertices in use
          if (({1'b0, idx} < tok_i.n) && row_r[tok_i.a]) row_nxt = row_r | tok_i.data;
        end
        OP_QUERY: begin
          if (tok_i.a == idx) tok_nxt.hit = row_r[tok_i.b];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= ident_row(idx);
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      row_r <= row_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

>>> rtl/core/rc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_seq: token sequencer at the head of the cell chain
// turns items into tokens and steps the closure one pivot at a time
// ----------------------------------------------------------------------------
module rc_seq import rc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [1:0]       in_kind,
  input  logic [VTX_W-1:0] in_a,
  input  logic [VTX_W-1:0] in_b,
  input  logic [CNT_W-1:0] n_act,
  input  tok_t             tail,
  output logic             in_ready,
  output tok_t             head
);

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_WAITF = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_FETCH = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [VTX_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] nsnap_r, nsnap_nxt;
  row_t             pivot_r, pivot_nxt;
  logic             in_rng;

  assign in_rng   = ({1'b0, in_a} < n_act) && ({1'b0, in_b} < n_act);
  assign in_ready = (state_r == S_RUN) && adv;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    nsnap_nxt = nsnap_r;
    pivot_nxt = pivot_r;
    head      = '0;
    head.a    = in_a;
    head.b    = in_b;
    unique case (state_r)
      S_RUN: begin
        if (in_valid && adv) begin
          case (in_kind)
            KIND_ADD: begin
              if (in_rng) begin
                head.valid = 1'b1;
                head.op    = OP_ADD;
              end
            end
            KIND_QUERY: begin
              head.valid = 1'b1;
              head.op    = OP_QUERY;
              head.oor   = !in_rng;
            end
            KIND_CLOSE: begin
              if (n_act != '0) begin
                nsnap_nxt  = n_act;
                k_nxt      = '0;
                head.valid = 1'b1;
                head.op    = OP_FETCH;
                head.a     = '0;
                head.n     = n_act;
                state_nxt  = S_WAITF;
              end
            end
            default: ;
          endcase
        end
      end
      S_WAITF: begin
        if (adv && tail.valid && (tail.op == OP_FETCH)) begin
          pivot_nxt = tail.data & low_mask(nsnap_r);
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (adv) begin
          head.valid = 1'b1;
          head.op    = OP_APPLY;
          head.a     = k_r;
          head.n     = nsnap_r;
          head.data  = pivot_r;
          if (CNT_W'({1'b0, k_r}) + CNT_W'(1) == nsnap_r) begin
            state_nxt = S_RUN;
          end else begin
            k_nxt     = k_r + VTX_W'(1);
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (adv) begin
          head.valid = 1'b1;
          head.op    = OP_FETCH;
          head.a     = k_r;
          head.n     = nsnap_r;
          state_nxt  = S_WAITF;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      k_r     <= '0;
      nsnap_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      nsnap_r <= nsnap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pivot_r <= pivot_nxt;
  end

endmodule

>>> bench/reach_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reach_check: prediction and checking for the reachability closure block
// follows item and register beats, keeps its own adjacency matrix, and
// compares each answer beat with the oldest answer due
// ----------------------------------------------------------------------------
module reach_check import rc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rc_in_if                  in_ch,
  rc_out_if                 out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic reachable;
    logic out_of_range;
  } answer_t;

  row_t             adj [MAX_VERTICES];
  logic [CFG_W-1:0] vcount;
  answer_t          answers_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int live_count();
    return (int'(vcount) > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
  endfunction

  task automatic report(input string what);
    $display("%0t reach_check: %s", $realtime, what);
    fail_count++;
  endtask

  // pivot sweeps limited to the vertices in use
  task automatic close_graph(input int n);
    row_t span;
    span = '0;
    for (int j = 0; j < n; j++) span[j] = 1'b1;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        if (adj[i][k]) adj[i] = adj[i] | (adj[k] & span);
      end
    end
  endtask

  task automatic take_item(input logic [1:0] kind, input logic [VTX_W-1:0] a,
                           input logic [VTX_W-1:0] b);
    int      n;
    answer_t ans;
    n = live_count();
    case (kind)
      KIND_ADD: begin
        if (int'(a) < n && int'(b) < n) begin
          adj[a][b] = 1'b1;
          adj[b][a] = 1'b1;
        end
      end
      KIND_CLOSE: begin
        close_graph(n);
      end
      KIND_QUERY: begin
        if (int'(a) < n && int'(b) < n) begin
          ans.reachable    = adj[a][b];
          ans.out_of_range = 1'b0;
        end else begin
          ans.reachable    = 1'b0;
          ans.out_of_range = 1'b1;
        end
        // append at the tail of the queue
        answers_due = {answers_due, ans};
      end
      default: begin
        // spare kind, dropped
      end
    endcase
  endtask

  always @(posedge clk) begin
    answer_t due;
    if (!rst_n) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj[i]    = '0;
        adj[i][i] = 1'b1;
      end
      vcount = CFG_W'(VC_RESET);
      answers_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_VC) begin
        vcount = pwdata[CFG_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        take_item(in_ch.kind, in_ch.vertex_a, in_ch.vertex_b);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          report("answer beat with no query waiting");
        end else begin
          due = answers_due.pop_front();
          if (out_ch.reachable !== due.reachable) begin
            report($sformatf("reachable %b, want %b", out_ch.reachable, due.reachable));
          end
          if (out_ch.out_of_range !== due.out_of_range) begin
            report($sformatf("out_of_range %b, want %b", out_ch.out_of_range,
                             due.out_of_range));
          end
        end
      end
    end
    pending = answers_due.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top of the reachability closure testbench
// drives edge, close, query and spare beats under several vertex counts, stalls the
// answer side at random and twice for a long stretch, and gives the verdict
// from the failure count of the checker
// ----------------------------------------------------------------------------
module tb import rc_pkg::*;;

  // kind code that the block has no use for
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // long enough for a close at full count to sweep every pivot down the chain
  localparam int SETTLE     = 66 * MAX_VERTICES + 100;
  localparam int DRAIN      = 200;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD       = 300;
  localparam int PHASES     = 6;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int errors;
  int pending;
  int stall_cycles;
  int answers_seen;
  bit quiet;

  // vertex count per phase: small, one, none, above the cap, full, odd size
  int phase_count [PHASES] = '{8, 1, 0, 127, 64, 13};
  int phase_items [PHASES] = '{120, 40, 40, 100, 130, 120};

  rc_in_if  in_ch ();
  rc_out_if out_ch ();

  reachability_closure uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  reach_check chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (errors),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // idle cycles before the next beat; none at all while a quiet stretch runs
  function automatic int idle_draw();
    return quiet ? 0 : int'($urandom_range(0, 10));
  endfunction

  // one item beat; valid stays up when the next item follows with no gap
  task automatic send_item(input logic [1:0] k, input logic [VTX_W-1:0] a,
                           input logic [VTX_W-1:0] b);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= k;
    in_ch.vertex_a <= a;
    in_ch.vertex_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // let every answer come home, then give a close in the chain time to end
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_count(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_VC;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly in range, often within a tight low cluster so closes find long
  // paths, now and then any vertex at all
  function automatic logic [VTX_W-1:0] pick_vertex(input int n);
    int r;
    r = $urandom_range(0, 9);
    if (n == 0 || r == 0) return VTX_W'($urandom_range(0, MAX_VERTICES - 1));
    if (r < 4) return VTX_W'($urandom_range(0, ((n < 6) ? n : 6) - 1));
    return VTX_W'($urandom_range(0, n - 1));
  endfunction

  task automatic random_items(input int n, input int count);
    int r;
    logic [1:0] k;
    for (int idx = 0; idx < count; idx++) begin
      if (idx % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      // closes kept rare, each one stalls the item side for a long sweep
      if (r < 45)      k = KIND_ADD;
      else if (r < 49) k = KIND_CLOSE;
      else if (r < 52) k = KIND_SPARE;
      else             k = KIND_QUERY;
      send_item(k, pick_vertex(n), pick_vertex(n));
    end
  endtask

  // answer side: random stalls, and two long hold-offs so the chain fills up
  // and the item side backs up behind it
  initial begin
    out_ch.ready <= 1'b0;
    answers_seen = 0;
    forever begin
      int gap;
      gap = (answers_seen == 20 || answers_seen == 250) ? HOLD : idle_draw();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      answers_seen++;
    end
  end

  // watchdog on cycles with no beat on any port
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n;
    quiet = 1'b0;
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_ADD;
    in_ch.vertex_a <= '0;
    in_ch.vertex_b <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset value of vertex_count, all 64 vertices in use
    // edge ends at both extremes, queries before and after a close
    send_item(KIND_ADD, 6'd0, 6'd63);
    send_item(KIND_ADD, 6'd63, 6'd5);
    send_item(KIND_QUERY, 6'd0, 6'd5);
    send_item(KIND_QUERY, 6'd63, 6'd0);
    send_item(KIND_CLOSE, 6'd0, 6'd0);
    send_item(KIND_QUERY, 6'd0, 6'd5);
    send_item(KIND_QUERY, 6'd5, 6'd0);
    // self edge, and a vertex that only reaches itself
    send_item(KIND_ADD, 6'd42, 6'd42);
    send_item(KIND_QUERY, 6'd42, 6'd42);
    send_item(KIND_QUERY, 6'd10, 6'd20);
    // spare kind gives no answer
    send_item(KIND_SPARE, 6'd63, 6'd63);
    send_item(KIND_SPARE, 6'd0, 6'd0);
    // a second component, joined to the first only after a later close
    send_item(KIND_ADD, 6'd62, 6'd1);
    send_item(KIND_ADD, 6'd1, 6'd21);
    send_item(KIND_QUERY, 6'd62, 6'd21);
    send_item(KIND_CLOSE, 6'd63, 6'd63);
    send_item(KIND_QUERY, 6'd21, 6'd62);
    send_item(KIND_QUERY, 6'd0, 6'd62);
    send_item(KIND_ADD, 6'd5, 6'd21);
    send_item(KIND_CLOSE, 6'd0, 6'd0);
    send_item(KIND_QUERY, 6'd0, 6'd62);

    // random phases; the matrix carries over from one count to the next
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_count(phase_count[p]);
      n = (phase_count[p] > MAX_VERTICES) ? MAX_VERTICES : phase_count[p];
      random_items(n, phase_items[p]);
      // trailing query, its answer marks the end of any close still running
      send_item(KIND_QUERY, pick_vertex(n), pick_vertex(n));
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
